>>> hw/rtl/bps_pkg.sv
// Shared types, constants and tables of the ballistic pitch solver.
`timescale 1ns / 1ps

package bps_pkg;

	localparam int ITERATIONS    = 30;
	localparam int CORDIC_STEPS  = 30;
	localparam int TAYLOR_TERMS  = 14;
	localparam int EXP_MAX_POW   = 28;
	localparam int DIV_T_STEPS   = 24;
	localparam int DIV_TAY_STEPS = 32;
	localparam int RND_W         = $clog2(ITERATIONS);

	localparam int CW = 42;
	localparam int AW = 34;

	localparam logic [30:0]           ONE30     = 31'd1073741824;
	localparam logic signed [AW-1:0]  HALF_PI30 = 34'sd1686629713;
	localparam logic signed [CW-1:0]  GAIN30    = 42'sd652032874;
	localparam logic [35:0]           LN2_30    = 36'd744261118;
	localparam logic signed [29:0]    CORR30    = 30'sd322122547;
	localparam logic [24:0]           T_CAP     = 25'd16777216;
	localparam logic signed [25:0]    H_LIM     = 26'sd16777216;

	localparam logic [1:0] CFG_MUZZLE_SPEED  = 2'd0;
	localparam logic [1:0] CFG_GRAVITY_ACCEL = 2'd1;
	localparam logic [1:0] CFG_DRAG_COEFF    = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_EXP_SUB, OP_EXP_HUGE, OP_TAY_INIT, OP_TAY_MUL,
		OP_DIV_STEP, OP_TAY_ACC, OP_EXP_FIN, OP_ATAN_INIT, OP_ATAN_STEP,
		OP_SC_INIT, OP_SC_STEP, OP_DEN_MUL, OP_T_ZERO, OP_T_CAP,
		OP_DIV_INIT_T, OP_T_TAKE, OP_MUL1, OP_MUL2, OP_MUL3, OP_H,
		OP_DZ_MUL, OP_AIM, OP_FINISH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] idx;
		logic       oor;
		logic       conv;
	} cmd_t;

	typedef struct packed {
		logic ge_ln2;
		logic n_max;
		logic num_zero;
		logic x_zero;
		logic cos_neg;
		logic tcap;
		logic h_zero;
		logic dz_zero;
	} sts_t;

	function automatic logic [29:0] atan_entry(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd843314857;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043837;
			5'd3:  r = 30'd133525159;
			5'd4:  r = 30'd67021687;
			5'd5:  r = 30'd33543516;
			5'd6:  r = 30'd16775851;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194283;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			5'd24: r = 30'd64;
			5'd25: r = 30'd32;
			5'd26: r = 30'd16;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/bps_in_if.sv
// Input channel of the ballistic pitch solver.
`timescale 1ns / 1ps

interface bps_in_if;
	logic               valid;
	logic               ready;
	logic [21:0]        horiz_distance;
	logic signed [22:0] target_height;

	modport source(output valid, horiz_distance, target_height, input ready);
	modport sink(input valid, horiz_distance, target_height, output ready);
endinterface

>>> hw/rtl/bps_out_if.sv
// Result channel of the ballistic pitch solver.
`timescale 1ns / 1ps

interface bps_out_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] pitch_angle;
	logic               out_of_range;
	logic               converged;

	modport source(output valid, pitch_angle, out_of_range, converged, input ready);
	modport sink(input valid, pitch_angle, out_of_range, converged, output ready);
endinterface

>>> hw/rtl/bps_datapath.sv
// Datapath of the pitch solver: registers, CORDIC unit, divider and multipliers.
`timescale 1ns / 1ps

module bps_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [21:0]        cfg_wdata,
	input  logic [21:0]        horiz_distance,
	input  logic signed [22:0] target_height,
	input  bps_pkg::cmd_t      cmd,
	output bps_pkg::sts_t      sts,
	output logic signed [17:0] pitch_angle,
	output logic               out_of_range,
	output logic               converged
);

	function automatic logic signed [25:0] clamp_h(input logic signed [41:0] v);
		logic signed [25:0] r;
		if (v > 42'(bps_pkg::H_LIM)) begin
			r = bps_pkg::H_LIM;
		end else if (v < -42'(bps_pkg::H_LIM)) begin
			r = -bps_pkg::H_LIM;
		end else begin
			r = v[25:0];
		end
		return r;
	endfunction

	logic [21:0] ms_q, ga_q;
	logic [15:0] dc_q;

	logic [21:0]                   s_q;
	logic signed [22:0]            z_q;
	logic [35:0]                   er_q;
	logic [4:0]                    n_q;
	logic                          huge_q;
	logic [21:0]                   kv_q;
	logic [30:0]                   term_q;
	logic [31:0]                   sum_q;
	logic [59:0]                   num_q;
	logic [31:0]                   dvd_q;
	logic [37:0]                   rem_q;
	logic [36:0]                   dsr_q;
	logic signed [bps_pkg::CW-1:0] cx_q, cy_q;
	logic signed [bps_pkg::AW-1:0] ca_q, pitch_q;
	logic [36:0]                   den_q;
	logic [24:0]                   t_q;
	logic signed [54:0]            pvs_q;
	logic [48:0]                   mvt_q;
	logic                          vneg_q;
	logic [46:0]                   mgt_q;
	logic [55:0]                   gtt_q;
	logic signed [33:0]            vt_q;
	logic signed [41:0]            h_q;
	logic signed [56:0]            prod_q;
	logic signed [25:0]            aim_q;
	logic signed [17:0]            opitch_q;
	logic                          ooor_q, oconv_q;

	logic [37:0]                   ks_prod, kv_prod;
	logic [60:0]                   tr;
	logic [38:0]                   trial, tdiff;
	logic                          qb;
	logic signed [bps_pkg::CW-1:0] dx, dy;
	logic signed [bps_pkg::AW-1:0] tab;
	logic [52:0]                   den_prod;
	logic signed [54:0]            pvs, vsr;
	logic signed [24:0]            vs;
	logic [24:0]                   vabs;
	logic [48:0]                   mvt;
	logic [46:0]                   mgt;
	logic [55:0]                   gtt;
	logic signed [33:0]            vt;
	logic signed [41:0]            h_new;
	logic signed [25:0]            hc;
	logic signed [26:0]            zdiff;
	logic signed [56:0]            prod, dzr;
	logic signed [26:0]            dz;
	logic signed [41:0]            aim_sum;
	logic signed [bps_pkg::AW-1:0] prnd, vert;

	always_comb begin
		ks_prod  = 38'(dc_q) * 38'(horiz_distance);
		kv_prod  = 38'(dc_q) * 38'(ms_q);
		tr       = 61'(term_q) * 61'(er_q[29:0]);
		trial    = {rem_q, dvd_q[31]};
		qb       = trial >= {2'b00, dsr_q};
		tdiff    = trial - {2'b00, dsr_q};
		dx       = cy_q >>> cmd.idx;
		dy       = cx_q >>> cmd.idx;
		tab      = $signed({4'b0000, bps_pkg::atan_entry(cmd.idx)});
		den_prod = 53'(kv_q) * 53'(cx_q[30:0]);
		pvs      = $signed({1'b0, ms_q}) * $signed(cy_q[31:0]);
		vsr      = pvs_q + 55'sd536870912;
		vs       = vsr[54:30];
		vabs     = vs[24] ? 25'(-vs) : 25'(vs);
		mvt      = 49'(vabs[23:0]) * 49'(t_q);
		mgt      = 47'(ga_q) * 47'(t_q);
		gtt      = 56'(mgt_q[46:16]) * 56'(t_q);
		vt       = vneg_q ? -$signed({1'b0, mvt_q[48:16]}) : $signed({1'b0, mvt_q[48:16]});
		h_new    = 42'(vt_q) - $signed({3'b000, gtt_q[55:17]});
		hc       = clamp_h(h_q);
		zdiff    = 27'(z_q) - 27'(hc);
		prod     = 57'(zdiff) * 57'(bps_pkg::CORR30);
		dzr      = prod_q + 57'sd536870912;
		dz       = dzr[56:30];
		aim_sum  = 42'(aim_q) + 42'(dz);
		prnd     = pitch_q + 34'sd8192;
		if (aim_q > 26'sd0) begin
			vert = bps_pkg::HALF_PI30;
		end else if (aim_q < 26'sd0) begin
			vert = -bps_pkg::HALF_PI30;
		end else begin
			vert = '0;
		end
	end

	always_comb begin
		sts.ge_ln2   = er_q >= bps_pkg::LN2_30;
		sts.n_max    = n_q == 5'(bps_pkg::EXP_MAX_POW);
		sts.num_zero = (num_q == '0) && !huge_q;
		sts.x_zero   = s_q == '0;
		sts.cos_neg  = cx_q[bps_pkg::CW-1];
		sts.tcap     = huge_q || (den_q == '0) || (num_q >= 60'({den_q, 8'h00}));
		sts.h_zero   = h_q == '0;
		sts.dz_zero  = dz == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= 22'd1638400;
			ga_q <= 22'd642253;
			dc_q <= 16'd655;
		end else if (cfg_we) begin
			case (cfg_index)
				bps_pkg::CFG_MUZZLE_SPEED:  ms_q <= cfg_wdata;
				bps_pkg::CFG_GRAVITY_ACCEL: ga_q <= cfg_wdata;
				bps_pkg::CFG_DRAG_COEFF:    dc_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			bps_pkg::OP_LOAD: begin
				s_q    <= horiz_distance;
				z_q    <= target_height;
				aim_q  <= 26'(target_height);
				er_q   <= ks_prod[37:2];
				kv_q   <= kv_prod[37:16];
				n_q    <= '0;
				huge_q <= 1'b0;
			end
			bps_pkg::OP_EXP_SUB: begin
				er_q <= er_q - bps_pkg::LN2_30;
				n_q  <= n_q + 5'd1;
			end
			bps_pkg::OP_EXP_HUGE: huge_q <= 1'b1;
			bps_pkg::OP_TAY_INIT: begin
				term_q <= bps_pkg::ONE30;
				sum_q  <= 32'(bps_pkg::ONE30);
			end
			bps_pkg::OP_TAY_MUL: begin
				dvd_q <= {1'b0, tr[60:30]};
				rem_q <= '0;
				dsr_q <= 37'(cmd.idx);
			end
			bps_pkg::OP_DIV_STEP: begin
				rem_q <= qb ? tdiff[37:0] : trial[37:0];
				dvd_q <= {dvd_q[30:0], qb};
			end
			bps_pkg::OP_TAY_ACC: begin
				term_q <= dvd_q[30:0];
				sum_q  <= sum_q + dvd_q;
			end
			bps_pkg::OP_EXP_FIN: num_q <= (60'(sum_q) << n_q) - 60'(bps_pkg::ONE30);
			bps_pkg::OP_ATAN_INIT: begin
				cx_q <= $signed({6'b000000, s_q, 14'h0000});
				cy_q <= 42'($signed({aim_q, 14'h0000}));
				ca_q <= sts.x_zero ? vert : '0;
			end
			bps_pkg::OP_ATAN_STEP: begin
				if (cy_q > 42'sd0) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					ca_q <= ca_q + tab;
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					ca_q <= ca_q - tab;
				end
			end
			bps_pkg::OP_SC_INIT: begin
				pitch_q <= ca_q;
				cx_q    <= bps_pkg::GAIN30;
				cy_q    <= '0;
			end
			bps_pkg::OP_SC_STEP: begin
				if (!ca_q[bps_pkg::AW-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					ca_q <= ca_q - tab;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					ca_q <= ca_q + tab;
				end
			end
			bps_pkg::OP_DEN_MUL: den_q <= den_prod[52:16];
			bps_pkg::OP_T_ZERO:  t_q <= '0;
			bps_pkg::OP_T_CAP:   t_q <= bps_pkg::T_CAP;
			bps_pkg::OP_DIV_INIT_T: begin
				rem_q <= num_q[45:8];
				dvd_q <= {num_q[7:0], 24'h000000};
				dsr_q <= den_q;
			end
			bps_pkg::OP_T_TAKE: t_q <= {1'b0, dvd_q[23:0]};
			bps_pkg::OP_MUL1:   pvs_q <= pvs;
			bps_pkg::OP_MUL2: begin
				mvt_q  <= mvt;
				vneg_q <= vs[24];
				mgt_q  <= mgt;
			end
			bps_pkg::OP_MUL3: begin
				gtt_q <= gtt;
				vt_q  <= vt;
			end
			bps_pkg::OP_H:      h_q <= h_new;
			bps_pkg::OP_DZ_MUL: prod_q <= prod;
			bps_pkg::OP_AIM:    aim_q <= clamp_h(aim_sum);
			bps_pkg::OP_FINISH: begin
				opitch_q <= cmd.oor ? 18'sd0 : prnd[31:14];
				ooor_q   <= cmd.oor;
				oconv_q  <= cmd.conv;
			end
			default: ;
		endcase
	end

	assign pitch_angle  = opitch_q;
	assign out_of_range = ooor_q;
	assign converged    = oconv_q;

endmodule

>>> hw/rtl/bps_ctrl.sv
// Sequencer of the pitch solver: walks the exp, CORDIC, divide and update steps.
`timescale 1ns / 1ps

module bps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bps_pkg::sts_t sts,
	output bps_pkg::cmd_t cmd
);

	typedef enum logic [20:0] {
		S_IDLE  = 21'd1 << 0,
		S_EXP   = 21'd1 << 1,
		S_TMUL  = 21'd1 << 2,
		S_TDIV  = 21'd1 << 3,
		S_TACC  = 21'd1 << 4,
		S_EFIN  = 21'd1 << 5,
		S_ATI   = 21'd1 << 6,
		S_ATS   = 21'd1 << 7,
		S_SCI   = 21'd1 << 8,
		S_SCS   = 21'd1 << 9,
		S_TSEL  = 21'd1 << 10,
		S_TCHK  = 21'd1 << 11,
		S_DIV   = 21'd1 << 12,
		S_TTAKE = 21'd1 << 13,
		S_M1    = 21'd1 << 14,
		S_M2    = 21'd1 << 15,
		S_M3    = 21'd1 << 16,
		S_H     = 21'd1 << 17,
		S_HCHK  = 21'd1 << 18,
		S_AIM   = 21'd1 << 19,
		S_FIN   = 21'd1 << 20
	} state_t;

	state_t                    state_q, nxt;
	logic [4:0]                cnt_q;
	logic [3:0]                tay_q;
	logic [bps_pkg::RND_W-1:0] rnd_q;
	logic                      oor_q, conv_q, out_valid_q;
	logic                      go_fin, fin_oor, fin_conv, can_fin;

	assign can_fin = !out_valid_q || out_ready;

	always_comb begin
		nxt      = state_q;
		cmd.op   = bps_pkg::OP_NONE;
		cmd.idx  = cnt_q;
		cmd.oor  = oor_q;
		cmd.conv = conv_q;
		go_fin   = 1'b0;
		fin_oor  = 1'b0;
		fin_conv = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = bps_pkg::OP_LOAD;
					nxt    = S_EXP;
				end
			end
			S_EXP: begin
				if (sts.ge_ln2) begin
					if (sts.n_max) begin
						cmd.op = bps_pkg::OP_EXP_HUGE;
						nxt    = S_ATI;
					end else begin
						cmd.op = bps_pkg::OP_EXP_SUB;
					end
				end else begin
					cmd.op = bps_pkg::OP_TAY_INIT;
					nxt    = S_TMUL;
				end
			end
			S_TMUL: begin
				cmd.op  = bps_pkg::OP_TAY_MUL;
				cmd.idx = {1'b0, tay_q};
				nxt     = S_TDIV;
			end
			S_TDIV: begin
				cmd.op = bps_pkg::OP_DIV_STEP;
				if (cnt_q == 5'(bps_pkg::DIV_TAY_STEPS - 1)) begin
					nxt = S_TACC;
				end
			end
			S_TACC: begin
				cmd.op = bps_pkg::OP_TAY_ACC;
				nxt    = (tay_q == 4'(bps_pkg::TAYLOR_TERMS)) ? S_EFIN : S_TMUL;
			end
			S_EFIN: begin
				cmd.op = bps_pkg::OP_EXP_FIN;
				nxt    = S_ATI;
			end
			S_ATI: begin
				cmd.op = bps_pkg::OP_ATAN_INIT;
				nxt    = sts.x_zero ? S_SCI : S_ATS;
			end
			S_ATS: begin
				cmd.op = bps_pkg::OP_ATAN_STEP;
				if (cnt_q == 5'(bps_pkg::CORDIC_STEPS - 1)) begin
					nxt = S_SCI;
				end
			end
			S_SCI: begin
				cmd.op = bps_pkg::OP_SC_INIT;
				nxt    = S_SCS;
			end
			S_SCS: begin
				cmd.op = bps_pkg::OP_SC_STEP;
				if (cnt_q == 5'(bps_pkg::CORDIC_STEPS - 1)) begin
					nxt = S_TSEL;
				end
			end
			S_TSEL: begin
				if (sts.num_zero) begin
					cmd.op = bps_pkg::OP_T_ZERO;
					nxt    = S_M1;
				end else if (sts.cos_neg) begin
					go_fin  = 1'b1;
					fin_oor = 1'b1;
					nxt     = S_FIN;
				end else begin
					cmd.op = bps_pkg::OP_DEN_MUL;
					nxt    = S_TCHK;
				end
			end
			S_TCHK: begin
				if (sts.tcap) begin
					cmd.op = bps_pkg::OP_T_CAP;
					nxt    = S_M1;
				end else begin
					cmd.op = bps_pkg::OP_DIV_INIT_T;
					nxt    = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = bps_pkg::OP_DIV_STEP;
				if (cnt_q == 5'(bps_pkg::DIV_T_STEPS - 1)) begin
					nxt = S_TTAKE;
				end
			end
			S_TTAKE: begin
				cmd.op = bps_pkg::OP_T_TAKE;
				nxt    = S_M1;
			end
			S_M1: begin
				cmd.op = bps_pkg::OP_MUL1;
				nxt    = S_M2;
			end
			S_M2: begin
				cmd.op = bps_pkg::OP_MUL2;
				nxt    = S_M3;
			end
			S_M3: begin
				cmd.op = bps_pkg::OP_MUL3;
				nxt    = S_H;
			end
			S_H: begin
				cmd.op = bps_pkg::OP_H;
				nxt    = S_HCHK;
			end
			S_HCHK: begin
				if (sts.h_zero) begin
					go_fin  = 1'b1;
					fin_oor = 1'b1;
					nxt     = S_FIN;
				end else begin
					cmd.op = bps_pkg::OP_DZ_MUL;
					nxt    = S_AIM;
				end
			end
			S_AIM: begin
				cmd.op = bps_pkg::OP_AIM;
				if (sts.dz_zero) begin
					go_fin   = 1'b1;
					fin_conv = 1'b1;
					nxt      = S_FIN;
				end else if (rnd_q == bps_pkg::RND_W'(bps_pkg::ITERATIONS - 1)) begin
					go_fin = 1'b1;
					nxt    = S_FIN;
				end else begin
					nxt = S_ATI;
				end
			end
			S_FIN: begin
				if (can_fin) begin
					cmd.op = bps_pkg::OP_FINISH;
					nxt    = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			tay_q       <= '0;
			rnd_q       <= '0;
			oor_q       <= 1'b0;
			conv_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			case (state_q)
				S_IDLE: rnd_q <= '0;
				S_EXP:  tay_q <= 4'd1;
				S_TMUL, S_ATI, S_SCI, S_TCHK: cnt_q <= '0;
				S_TDIV, S_ATS, S_SCS, S_DIV:  cnt_q <= cnt_q + 5'd1;
				S_TACC: tay_q <= tay_q + 4'd1;
				S_AIM:  rnd_q <= rnd_q + bps_pkg::RND_W'(1);
				default: ;
			endcase
			if (go_fin) begin
				oor_q  <= fin_oor;
				conv_q <= fin_conv;
			end
			if (state_q == S_FIN && can_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/ballistic_pitch_solver_unit.sv
// Top level of the ballistic pitch solver: sequencer plus datapath.
`timescale 1ns / 1ps

// Usage: a word on in_ch carries a horizontal distance and a target height.
// The block answers each word with one word on out_ch holding the pitch
// angle and the out-of-range and converged flags. Registers are written on
// the cfg port (index 0 speed, 1 gravity, 2 drag); the user must write them
// only while the block is idle, as the block itself does not enforce it.
// One word is solved at a time. The exp setup runs the ln 2 range reduction
// steps, then 14 series terms, each divided on the 32-step shared divider.
// Each round then runs two 30-step CORDIC passes with their setup steps, a
// 24-step divide unless the flight time is zero or capped, and the select,
// multiply and update steps. Up to 30 rounds run.
// in_ch.ready is high only while the sequencer is idle; a new word may be
// taken while the previous result still sits in the output register.
// When out_ch is stalled, the finished result waits in the sequencer until
// the output register frees. Reset empties the block and restores the
// default register values.

module ballistic_pitch_solver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [21:0] cfg_wdata,
	bps_in_if.sink      in_ch,
	bps_out_if.source   out_ch
);

	bps_pkg::cmd_t cmd;
	bps_pkg::sts_t sts;

	bps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bps_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.horiz_distance (in_ch.horiz_distance),
		.target_height  (in_ch.target_height),
		.cmd            (cmd),
		.sts            (sts),
		.pitch_angle    (out_ch.pitch_angle),
		.out_of_range   (out_ch.out_of_range),
		.converged      (out_ch.converged)
	);

endmodule
